>>> rtl/round_robin_quantum_scheduler_assert.svh
// ----------------------------------------------------------------------------
// round robin quantum scheduler assertion macros
// property wrappers clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define RRQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRQS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rrqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_pkg
// shared types and constants of the round robin quantum scheduler
// ----------------------------------------------------------------------------
package rrqs_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_PROC = 2'd1,
    CMD_UNLD = 2'd2
  } cmd_t;

  localparam logic KIND_PROC = 1'b0;
  localparam logic KIND_UNLD = 1'b1;

  localparam int WAIT_DEPTH_DEF  = 16;
  localparam int RING_DEPTH_DEF  = 16;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [15:0] QUANTUM_RST = 16'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] job_id;
    logic [15:0] job_time;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic        found;
    logic [15:0] out_id;
    logic [15:0] out_time;
    logic        overflow;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] rem;
  } job_t;

endpackage

>>> rtl/round_robin_quantum_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// round-robin time-slice scheduler: waiting fifo, job ring, finished stack
// ----------------------------------------------------------------------------
//   channel | ports                         | moves
//   --------+-------------------------------+------------------------------
//   in      | in_valid, in_stall, in_req    | LOAD / PROC / UNLD requests
//   out     | out_valid, out_stall, out_rsp | PROC and UNLD reports
//   cfg     | cfg_wr_en, cfg_wr_data        | quantum register write
//
// one request enters per cycle while in_stall is low; its report leaves through
// the input register, then the result register. ring head, ring second entry,
// waiting head and stack top sit in prefetch registers fed by registered
// memory reads, so the work stage never waits on a memory read.
// reset clears all counts and pointers and sets quantum to 1; no memory sweep.
// out_stall holds the result register, which then holds the input register.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler #(
  parameter int WAIT_DEPTH  = rrqs_pkg::WAIT_DEPTH_DEF,
  parameter int RING_DEPTH  = rrqs_pkg::RING_DEPTH_DEF,
  parameter int STACK_DEPTH = rrqs_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrqs_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output rrqs_pkg::out_rsp_t out_rsp,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);
  import rrqs_pkg::*;

  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int RCW = $clog2(RING_DEPTH + 1);
  localparam int RING_PHYS = (RING_DEPTH < 4) ? 4 : ((RING_DEPTH + 1) / 2) * 2;
  localparam int RING_ROWS = RING_PHYS / 2;
  localparam int PW  = $clog2(RING_PHYS);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  // control and config registers
  logic [15:0]    quantum_r;
  logic           in_valid_r, in_valid_nxt;
  in_req_t        in_req_r;
  logic           out_valid_r, out_valid_nxt;
  out_rsp_t       out_rsp_r, out_rsp_nxt;
  logic           drop_pend_r, drop_pend_nxt;

  logic [WAW-1:0] wait_head_r, wait_head_nxt;
  logic [WCW-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [PW-1:0]  ring_head_r, ring_head_nxt;
  logic [RCW-1:0] ring_cnt_r, ring_cnt_nxt;
  logic [SCW-1:0] done_cnt_r, done_cnt_nxt;
  job_t           head_job_r, head_job_nxt;
  job_t           tail_job_r, tail_job_nxt;

  // memories and their registered read data
  job_t           wait_mem [WAIT_DEPTH];
  job_t           ring_mem0 [RING_ROWS];
  job_t           ring_mem1 [RING_ROWS];
  logic [15:0]    done_mem [STACK_DEPTH];
  job_t           wait_rd_r;
  job_t           ring_rd0_r, ring_rd1_r;
  logic           ring_rd_odd_r;
  logic [15:0]    done_rd_r;

  logic           wait_we;
  logic [WAW-1:0] wait_widx, wait_ridx;
  logic           ring_we0, ring_we1;
  logic [PW-2:0]  ring_wrow0, ring_wrow1, ring_rrow;
  job_t           ring_wd0, ring_wd1;
  logic [PW-1:0]  ring_rd_pos;
  logic           done_we;
  logic [SAW-1:0] done_widx, done_ridx;
  logic [SCW-1:0] done_cnt_dec;

  // work stage terms
  logic           out_ready, fire;
  logic           tail_zero, done_full, wait_full, wait_has, admit, rotate;
  logic [RCW-1:0] n1, n2;
  job_t           head_src, charged_job, ring_next;
  logic [15:0]    charged;
  logic [PW:0]    pos_w_sum, pos_c_sum;
  logic [PW-1:0]  pos_w, pos_c;
  logic [WAW:0]   wait_sum;
  logic [WAW-1:0] wait_head_inc;

  assign out_ready = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // tail job is always the one charged last, so only its time is checked
  assign tail_zero = (ring_cnt_r != '0) && (tail_job_r.rem == '0);
  assign done_full = done_cnt_r == SCW'(STACK_DEPTH);
  assign wait_full = wait_cnt_r == WCW'(WAIT_DEPTH);
  assign wait_has  = wait_cnt_r != '0;
  assign n1        = ring_cnt_r - RCW'(tail_zero);
  assign admit     = wait_has && (n1 < RCW'(RING_DEPTH));
  assign n2        = n1 + RCW'(admit);
  assign rotate    = n2 > RCW'(1);

  assign head_src    = (n1 == '0) ? wait_rd_r : head_job_r;
  assign charged     = (head_src.rem > quantum_r) ? head_src.rem - quantum_r : '0;
  assign charged_job = '{id: head_src.id, rem: charged};
  assign ring_next   = ring_rd_odd_r ? ring_rd1_r : ring_rd0_r;

  assign pos_w_sum = {1'b0, ring_head_r} + (PW+1)'(n1);
  assign pos_c_sum = {1'b0, ring_head_r} + (PW+1)'(n2);
  assign pos_w = (pos_w_sum >= (PW+1)'(RING_PHYS)) ?
                 PW'(pos_w_sum - (PW+1)'(RING_PHYS)) : pos_w_sum[PW-1:0];
  assign pos_c = (pos_c_sum >= (PW+1)'(RING_PHYS)) ?
                 PW'(pos_c_sum - (PW+1)'(RING_PHYS)) : pos_c_sum[PW-1:0];

  assign wait_sum  = {1'b0, wait_head_r} + (WAW+1)'(wait_cnt_r);
  assign wait_widx = (wait_sum >= (WAW+1)'(WAIT_DEPTH)) ?
                     WAW'(wait_sum - (WAW+1)'(WAIT_DEPTH)) : wait_sum[WAW-1:0];
  assign wait_head_inc = (wait_head_r == WAW'(WAIT_DEPTH - 1)) ? '0 :
                         wait_head_r + WAW'(1);
  assign done_widx = done_cnt_r[SAW-1:0];

  always_comb begin
    in_valid_nxt  = (in_valid && !in_stall) || (in_valid_r && !fire);
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    drop_pend_nxt = drop_pend_r;
    wait_head_nxt = wait_head_r;
    wait_cnt_nxt  = wait_cnt_r;
    ring_head_nxt = ring_head_r;
    ring_cnt_nxt  = ring_cnt_r;
    done_cnt_nxt  = done_cnt_r;
    head_job_nxt  = head_job_r;
    tail_job_nxt  = tail_job_r;
    wait_we       = 1'b0;
    done_we       = 1'b0;
    ring_we0      = 1'b0;
    ring_we1      = 1'b0;
    ring_wrow0    = pos_w[PW-1:1];
    ring_wrow1    = pos_w[PW-1:1];
    ring_wd0      = wait_rd_r;
    ring_wd1      = wait_rd_r;

    if (fire) begin
      case (in_req_r.command)
        CMD_LOAD: begin
          if (wait_full) begin
            drop_pend_nxt = 1'b1;
          end else begin
            wait_we      = 1'b1;
            wait_cnt_nxt = wait_cnt_r + WCW'(1);
          end
        end
        CMD_PROC: begin
          if (tail_zero && !done_full) begin
            done_we      = 1'b1;
            done_cnt_nxt = done_cnt_r + SCW'(1);
          end
          if (wait_has) begin
            wait_head_nxt = wait_head_inc;
            wait_cnt_nxt  = wait_cnt_r - WCW'(1);
          end
          // admitted and rotated entries land on opposite banks
          if (admit) begin
            if (pos_w[0]) begin
              ring_we1 = 1'b1;
            end else begin
              ring_we0 = 1'b1;
            end
          end
          if (rotate) begin
            if (pos_c[0]) begin
              ring_we1   = 1'b1;
              ring_wrow1 = pos_c[PW-1:1];
              ring_wd1   = charged_job;
            end else begin
              ring_we0   = 1'b1;
              ring_wrow0 = pos_c[PW-1:1];
              ring_wd0   = charged_job;
            end
            ring_head_nxt = (ring_head_r == PW'(RING_PHYS - 1)) ? '0 :
                            ring_head_r + PW'(1);
          end
          ring_cnt_nxt = n2;
          if (n2 != '0) begin
            tail_job_nxt = charged_job;
            if (!rotate) begin
              head_job_nxt = charged_job;
            end else if (n1 == RCW'(1)) begin
              head_job_nxt = wait_rd_r;
            end else begin
              head_job_nxt = ring_next;
            end
          end
          out_valid_nxt        = 1'b1;
          drop_pend_nxt        = 1'b0;
          out_rsp_nxt.kind     = KIND_PROC;
          out_rsp_nxt.found    = n2 != '0;
          out_rsp_nxt.out_id   = (n2 != '0) ? head_src.id : '0;
          out_rsp_nxt.out_time = (n2 != '0) ? charged : '0;
          out_rsp_nxt.overflow = (tail_zero && done_full) || (wait_has && !admit) ||
                                 drop_pend_r;
        end
        CMD_UNLD: begin
          if (done_cnt_r != '0) begin
            done_cnt_nxt = done_cnt_r - SCW'(1);
          end
          out_valid_nxt        = 1'b1;
          drop_pend_nxt        = 1'b0;
          out_rsp_nxt.kind     = KIND_UNLD;
          out_rsp_nxt.found    = done_cnt_r != '0;
          out_rsp_nxt.out_id   = (done_cnt_r != '0) ? done_rd_r : '0;
          out_rsp_nxt.out_time = '0;
          out_rsp_nxt.overflow = drop_pend_r;
        end
        default: begin
        end
      endcase
    end
  end

  // prefetch addresses follow the next-state pointers
  assign ring_rd_pos  = (ring_head_nxt == PW'(RING_PHYS - 1)) ? '0 :
                        ring_head_nxt + PW'(1);
  assign ring_rrow    = ring_rd_pos[PW-1:1];
  assign wait_ridx    = wait_head_nxt;
  assign done_cnt_dec = done_cnt_nxt - SCW'(1);
  assign done_ridx    = (done_cnt_nxt == '0) ? '0 : SAW'(done_cnt_dec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QUANTUM_RST;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      drop_pend_r <= 1'b0;
      wait_head_r <= '0;
      wait_cnt_r  <= '0;
      ring_head_r <= '0;
      ring_cnt_r  <= '0;
      done_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      drop_pend_r <= drop_pend_nxt;
      wait_head_r <= wait_head_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      ring_head_r <= ring_head_nxt;
      ring_cnt_r  <= ring_cnt_nxt;
      done_cnt_r  <= done_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_req;
    end
    out_rsp_r  <= out_rsp_nxt;
    head_job_r <= head_job_nxt;
    tail_job_r <= tail_job_nxt;
  end

  // memories: one write and one registered read each, write-first on a match
  always_ff @(posedge clk) begin
    if (wait_we) begin
      wait_mem[wait_widx] <= '{id: in_req_r.job_id, rem: in_req_r.job_time};
    end
    wait_rd_r <= (wait_we && (wait_widx == wait_ridx)) ?
                 job_t'{id: in_req_r.job_id, rem: in_req_r.job_time} : wait_mem[wait_ridx];
  end

  always_ff @(posedge clk) begin
    if (ring_we0) begin
      ring_mem0[ring_wrow0] <= ring_wd0;
    end
    if (ring_we1) begin
      ring_mem1[ring_wrow1] <= ring_wd1;
    end
    ring_rd0_r    <= (ring_we0 && (ring_wrow0 == ring_rrow)) ? ring_wd0 : ring_mem0[ring_rrow];
    ring_rd1_r    <= (ring_we1 && (ring_wrow1 == ring_rrow)) ? ring_wd1 : ring_mem1[ring_rrow];
    ring_rd_odd_r <= ring_rd_pos[0];
  end

  always_ff @(posedge clk) begin
    if (done_we) begin
      done_mem[done_widx] <= tail_job_r.id;
    end
    done_rd_r <= (done_we && (done_widx == done_ridx)) ? tail_job_r.id : done_mem[done_ridx];
  end

endmodule

>>> rtl/rrqs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_checker
// port-level checks of the round robin quantum scheduler, bound to the top
// ----------------------------------------------------------------------------
`include "round_robin_quantum_scheduler_assert.svh"

module rrqs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rrqs_pkg::out_rsp_t out_rsp
);

  `RRQS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rsp), "stalled report changed")

  // a newly raised report must follow a taken request, by way of the input and result registers
  `RRQS_ASSERT_IMP(a_out_latency, $rose(out_valid), $past(in_valid && !in_stall, 2), "report without request")

  `RRQS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "request stalled while output is free")

  `RRQS_ASSERT_IMP(a_reset_idle, $past(!rst_n), !out_valid, "report valid right after reset")

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

>>> verif/tb_round_robin_quantum_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_quantum_scheduler
// drives LOAD / PROC / UNLD requests and the unused command code into the scheduler under random gaps and
// back-pressure, keeps its own copy of the waiting fifo, job ring and finished
// stack to predict every report, and compares each report field by field
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler;
  import rrqs_pkg::*;

  localparam int WAIT_D       = WAIT_DEPTH_DEF;
  localparam int RING_D       = RING_DEPTH_DEF;
  localparam int STACK_D      = STACK_DEPTH_DEF;
  localparam int SETTLE       = 8;
  localparam int MAX_CYCLES   = 800000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_stall;
  out_rsp_t    out_rsp;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  round_robin_quantum_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // scheduler state as predicted
  job_t        wait_mem [WAIT_D];
  int          wait_rd;
  int          wait_cnt;
  job_t        ring_mem [RING_D];
  int          ring_hd;
  int          ring_cnt;
  logic [15:0] done_mem [STACK_D];
  int          done_cnt;
  bit          drop_flag;
  logic [15:0] quantum_q;

  out_rsp_t    expected_reports[$];
  out_rsp_t    want_rsp;
  int          err_count;
  int          cycle_count;
  bit          offering;
  bit          idle_in;
  bit          idle_out;
  int          hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] rnd16(int lo, int hi);
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic in_req_t mk_req(logic [1:0] cmd, logic [15:0] id, logic [15:0] tm);
    in_req_t r;
    r.command  = cmd;
    r.job_id   = id;
    r.job_time = tm;
    return r;
  endfunction

  function automatic in_req_t rand_req(int pct_load, int pct_proc, int tmax);
    in_req_t r;
    int      pick;
    pick     = $urandom_range(0, 99);
    r.job_id = rnd16(0, 65535);
    if ($urandom_range(0, 9) == 0) r.job_time = rnd16(0, 65535);
    else r.job_time = rnd16(0, tmax);
    if (pick < 3) r.command = CMD_SPARE;
    else if (pick < 3 + pct_load) r.command = CMD_LOAD;
    else if (pick < 3 + pct_load + pct_proc) r.command = CMD_PROC;
    else r.command = CMD_UNLD;
    return r;
  endfunction

  // apply one accepted request to the predicted state
  task automatic schedule_step(in_req_t r);
    out_rsp_t rsp;
    job_t     e;
    bit       ovf;
    int       tpos;
    ovf = 1'b0;
    rsp = '0;
    case (r.command)
      CMD_LOAD: begin
        if (wait_cnt < WAIT_D) begin
          e.id  = r.job_id;
          e.rem = r.job_time;
          wait_mem[(wait_rd + wait_cnt) % WAIT_D] = e;
          wait_cnt++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      CMD_PROC: begin
        // finished tail job goes to the stack first
        if (ring_cnt > 0) begin
          tpos = (ring_hd + ring_cnt - 1) % RING_D;
          e = ring_mem[tpos];
          if (e.rem == 16'd0) begin
            ring_cnt--;
            if (done_cnt < STACK_D) begin
              done_mem[done_cnt] = e.id;
              done_cnt++;
            end else begin
              ovf = 1'b1;
            end
          end
        end
        if (wait_cnt > 0) begin
          e = wait_mem[wait_rd];
          wait_rd = (wait_rd + 1) % WAIT_D;
          wait_cnt--;
          if (ring_cnt < RING_D) begin
            ring_mem[(ring_hd + ring_cnt) % RING_D] = e;
            ring_cnt++;
          end else begin
            ovf = 1'b1;
          end
        end
        rsp.kind = KIND_PROC;
        if (ring_cnt > 0) begin
          e = ring_mem[ring_hd];
          e.rem = (e.rem > quantum_q) ? e.rem - quantum_q : 16'd0;
          ring_mem[ring_hd] = e;
          rsp.found    = 1'b1;
          rsp.out_id   = e.id;
          rsp.out_time = e.rem;
          if (ring_cnt > 1) begin
            ring_mem[(ring_hd + ring_cnt) % RING_D] = e;
            ring_hd = (ring_hd + 1) % RING_D;
          end
        end
        rsp.overflow = ovf | drop_flag;
        drop_flag = 1'b0;
        expected_reports.push_back(rsp);
      end
      CMD_UNLD: begin
        rsp.kind = KIND_UNLD;
        if (done_cnt > 0) begin
          done_cnt--;
          rsp.found  = 1'b1;
          rsp.out_id = done_mem[done_cnt];
        end
        rsp.overflow = drop_flag;
        drop_flag = 1'b0;
        expected_reports.push_back(rsp);
      end
      default: ;
    endcase
  endtask

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // report checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        report_error("report with no request pending");
      end else begin
        want_rsp = expected_reports.pop_front();
        check_field("kind", 16'(out_rsp.kind), 16'(want_rsp.kind));
        check_field("found", 16'(out_rsp.found), 16'(want_rsp.found));
        check_field("out_id", out_rsp.out_id, want_rsp.out_id);
        check_field("out_time", out_rsp.out_time, want_rsp.out_time);
        check_field("overflow", 16'(out_rsp.overflow), 16'(want_rsp.overflow));
      end
    end
  end

  // receiver back-pressure, with a long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (idle_out && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(in_req_t r);
    in_req <= r;
    if (!offering) begin
      in_valid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (in_stall);
    schedule_step(r);
    if (idle_in && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic drain_reports();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_reports.size() != 0) @(posedge clk);
    // a trailing LOAD leaves no report, so let the pipeline empty
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reprogram_quantum(logic [15:0] q);
    drain_reports();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    quantum_q = q;
  endtask

  task automatic test_directed();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));   // empty ring
    send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));   // empty stack
    send_req(mk_req(CMD_LOAD, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_LOAD, 16'hFFFF, 16'hFFFF));
    send_req(mk_req(CMD_SPARE, 16'hFFFF, 16'hFFFF));  // unused code, ignored
    send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));   // zero-time tail finishes
    send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_LOAD, 16'h1234, 16'h0002));
    repeat (5) send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));
    reprogram_quantum(16'h0000);
    send_req(mk_req(CMD_LOAD, 16'hA5A5, 16'h0000));
    send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    reprogram_quantum(16'hFFFF);
    repeat (3) send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    repeat (2) send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));
    drain_reports();
  endtask

  task automatic test_wait_overflow();
    reprogram_quantum(16'h0001);
    repeat (WAIT_D + 2) send_req(mk_req(CMD_LOAD, rnd16(0, 65535), rnd16(1, 65535)));
    send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_LOAD, 16'h5A5A, 16'h0007));
    send_req(mk_req(CMD_LOAD, 16'hC3C3, 16'h0009));
    send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));
    drain_reports();
  endtask

  task automatic test_ring_overflow();
    // quantum 0 keeps jobs alive so the ring fills
    reprogram_quantum(16'h0000);
    repeat (RING_D) send_req(mk_req(CMD_LOAD, rnd16(0, 65535), rnd16(1, 65535)));
    repeat (RING_D + 2) send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    repeat (6) begin
      send_req(mk_req(CMD_LOAD, rnd16(0, 65535), rnd16(1, 65535)));
      send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    end
    drain_reports();
  endtask

  task automatic test_stack_overflow();
    // every slice empties a job, so the stack fills without unloads
    reprogram_quantum(16'hFFFF);
    repeat (STACK_D + 1) send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));
    repeat (5) begin
      repeat (4) send_req(mk_req(CMD_LOAD, rnd16(0, 65535), rnd16(0, 65535)));
      repeat (6) send_req(mk_req(CMD_PROC, 16'h0000, 16'h0000));
    end
    repeat (STACK_D + 2) send_req(mk_req(CMD_UNLD, 16'h0000, 16'h0000));
    drain_reports();
  endtask

  task automatic test_backpressure();
    reprogram_quantum(16'h0002);
    idle_in  = 1'b0;
    hold_len = 300;
    repeat (40) send_req(rand_req(40, 45, 6));
    // sender pauses until every report is back
    drain_reports();
    idle_in = 1'b1;
  endtask

  task automatic test_random();
    logic [15:0] qs [7];
    int          p;
    qs = '{16'h0001, 16'h0000, 16'h0003, 16'hFFFF, 16'h0000, 16'h0002, 16'h0005};
    qs[4] = rnd16(0, 65535);
    for (p = 0; p < 7; p++) begin
      reprogram_quantum(qs[p]);
      case (p % 4)
        0: begin idle_in = 1'b1; idle_out = 1'b1; end
        1: begin idle_in = 1'b0; idle_out = 1'b0; end
        2: begin idle_in = 1'b1; idle_out = 1'b0; end
        default: begin idle_in = 1'b0; idle_out = 1'b1; end
      endcase
      repeat (140) send_req(rand_req(45, 38, 8));
    end
    idle_in  = 1'b1;
    idle_out = 1'b1;
    drain_reports();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req      = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    offering    = 1'b0;
    idle_in     = 1'b0;
    idle_out    = 1'b0;
    hold_len    = 0;
    err_count   = 0;
    wait_rd     = 0;
    wait_cnt    = 0;
    ring_hd     = 0;
    ring_cnt    = 0;
    done_cnt    = 0;
    drop_flag   = 1'b0;
    quantum_q   = QUANTUM_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_wait_overflow();
    test_ring_overflow();
    test_stack_overflow();
    test_backpressure();
    test_random();

    if (err_count == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
